>>> rtl/kma_pkg.sv
// Shared types and constants of the key matrix auto-repeat block.
`default_nettype none

package kma_pkg;

    // Width of the configuration registers and of the config data port.
    localparam int CFG_W = 16;

    // Configuration register indexes.
    localparam logic REG_LONG_DELAY = 1'b0;
    localparam logic REG_REPEAT     = 1'b1;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] LONG_DELAY_RST = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd50;

    // Input command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FUNC   = 1'b1;

    // Result event kinds.
    localparam logic EV_KEY = 1'b0;
    localparam logic EV_SET = 1'b1;

    // Active mapping set runs from SET_FIRST to SET_LAST and wraps.
    localparam logic [1:0] SET_FIRST = 2'd1;
    localparam logic [1:0] SET_LAST  = 2'd3;

    // Depth of the result queue.
    localparam int OUT_DEPTH = 3;

    typedef struct packed {
        logic       event_kind;
        logic [3:0] key_index;
        logic [1:0] active_set;
        logic       is_repeat;
    } event_t;

endpackage

`default_nettype wire

>>> rtl/kma_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module kma_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 12
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/kma_key_update.sv
// Read-modify-write rule for one key's hold counter and long-press flag.
`default_nettype none

module kma_key_update #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic [COUNT_BITS-1:0]      cnt_in,
    input  wire logic                       flag_in,
    input  wire logic [kma_pkg::CFG_W-1:0]  long_delay,
    input  wire logic [kma_pkg::CFG_W-1:0]  repeat_period,
    output logic      [COUNT_BITS-1:0]      cnt_out,
    output logic                            flag_out,
    output logic                            emit,
    output logic                            is_repeat
);

    localparam int CMP_W = (COUNT_BITS > kma_pkg::CFG_W) ? COUNT_BITS : kma_pkg::CFG_W;

    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      delay_ext;
    logic [CMP_W-1:0]      period_ext;
    logic [COUNT_BITS-1:0] cnt_mid;

    assign cnt_ext    = CMP_W'(cnt_in);
    assign delay_ext  = CMP_W'(long_delay);
    assign period_ext = CMP_W'(repeat_period);

    always_comb begin
        emit      = 1'b0;
        is_repeat = 1'b0;
        flag_out  = flag_in;
        cnt_mid   = cnt_in;
        if (cnt_in == '0) begin
            emit = 1'b1;
        end else if (flag_in && (cnt_ext > period_ext)) begin
            // Repeat keystroke; the count restarts so that it reads 2 after the increment.
            emit      = 1'b1;
            is_repeat = 1'b1;
            cnt_mid   = COUNT_BITS'(1);
        end else if (cnt_ext > delay_ext) begin
            flag_out = 1'b1;
        end
        // Saturating increment.
        cnt_out = (&cnt_mid) ? cnt_mid : cnt_mid + COUNT_BITS'(1);
    end

endmodule

`default_nettype wire

>>> rtl/kma_out_fifo.sv
// Small result queue that decouples the update stage from the output channel.
`default_nettype none

module kma_out_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire kma_pkg::event_t push_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output kma_pkg::event_t      pop_data,
    output logic [1:0]           count
);

    localparam logic [1:0] LAST_PTR = 2'(kma_pkg::OUT_DEPTH - 1);

    kma_pkg::event_t slot_reg [kma_pkg::OUT_DEPTH];
    logic [1:0]      wptr_reg;
    logic [1:0]      wptr_next;
    logic [1:0]      rptr_reg;
    logic [1:0]      rptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            pop;

    assign m_valid  = (count_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    assign pop_data = slot_reg[rptr_reg];
    assign count    = count_reg;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == LAST_PTR) ? 2'd0 : wptr_reg + 2'd1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == LAST_PTR) ? 2'd0 : rptr_reg + 2'd1;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/key_matrix_autorepeat.sv
// Top level of the key matrix scanner with typematic auto-repeat.
//
// Usage: the input channel (s_*) carries either one key sample (row, column,
// sensed level) or a function-button press. The result channel (m_*) carries
// keystroke events and active-set change reports; an input causes at most one
// result. The configuration port (cfg_*) writes the long-press delay (index 0)
// and the repeat period (index 1), one write per cycle, no read-back.
// Path: an input is registered into the update stage, which writes any result
// into the result queue that drives m_valid. Throughput: one input transfer per
// cycle while s_ready is high. Each key's counter and flag live in a small RAM
// with one read port and one write port; a sample reads its entry in the
// transfer cycle and writes it back in the next, and a back-to-back sample of
// the same key takes the value being written through a bypass.
// Reset: synchronous; at the first clock edge with aresetn low all counters and
// flags come to read as zero (per-entry valid bits), the active set becomes 1,
// the delay 500 and the period 50.
// Stall: results collect in a three-entry queue; s_ready falls only when the
// queue and the update stage together could fill it, and rises again as soon
// as the receiver takes a result.
`default_nettype none

module key_matrix_autorepeat #(
    parameter int ROWS        = 3,
    parameter int COLS        = 4,
    parameter int ACTIVE_KEYS = 10,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Input channel.
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_cmd,
    input  wire logic [1:0]                 s_row,
    input  wire logic [1:0]                 s_col,
    input  wire logic                       s_pressed,
    // Result channel.
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_event_kind,
    output logic [3:0]                      m_key_index,
    output logic [1:0]                      m_active_set,
    output logic                            m_is_repeat,
    // Configuration port.
    input  wire logic                       cfg_wen,
    input  wire logic                       cfg_addr,
    input  wire logic [kma_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int NUM_KEYS = ROWS * COLS;
    localparam int AW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int EW       = COUNT_BITS + 1;

    // Configuration registers.
    logic [kma_pkg::CFG_W-1:0] long_delay_reg;
    logic [kma_pkg::CFG_W-1:0] repeat_period_reg;

    // Active mapping set.
    logic [1:0] current_set_reg;
    logic [1:0] current_set_next;

    // Front end: decode the incoming sample and issue the RAM read.
    logic       s_accept;
    logic [7:0] key_full;
    logic       key_hit;
    logic       key_active;

    // Update stage registers.
    logic          s1_valid_reg;
    logic          s1_cmd_reg;
    logic          s1_hit_reg;
    logic          s1_pressed_reg;
    logic          s1_active_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [3:0]    s1_kidx_reg;

    // Per-entry valid bits: an entry never written reads as zero.
    logic [NUM_KEYS-1:0] entry_valid_reg;

    // Bypass of the write made in the previous cycle.
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [EW-1:0] fwd_data_reg;

    logic [EW-1:0]         ram_rdata;
    logic [EW-1:0]         entry_cur;
    logic [EW-1:0]         entry_new;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] upd_cnt;
    logic                  upd_flag;
    logic                  upd_emit;
    logic                  upd_rep;

    logic            fifo_push;
    kma_pkg::event_t fifo_din;
    kma_pkg::event_t fifo_dout;
    logic [1:0]      fifo_count;
    logic [2:0]      occupancy;

    // ------------------------------------------------------------------
    // Input side. The queue must have room for every item already in
    // flight plus the one being taken now.
    // ------------------------------------------------------------------
    assign occupancy = {1'b0, fifo_count} + {2'b00, s1_valid_reg};
    assign s_ready   = (occupancy < 3'(kma_pkg::OUT_DEPTH));
    assign s_accept  = s_valid && s_ready;

    assign key_full   = 8'(s_row) * 8'(COLS) + 8'(s_col);
    assign key_hit    = (s_cmd == kma_pkg::CMD_SAMPLE) &&
                        (8'(s_row) < 8'(ROWS)) && (8'(s_col) < 8'(COLS));
    assign key_active = ({1'b0, key_full} < 9'(ACTIVE_KEYS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg     <= s_cmd;
            s1_hit_reg     <= key_hit;
            s1_pressed_reg <= s_pressed;
            s1_active_reg  <= key_active;
            s1_addr_reg    <= key_full[AW-1:0];
            s1_kidx_reg    <= key_full[3:0];
        end
    end

    // ------------------------------------------------------------------
    // Key state memory: {long flag, hold count} per key.
    // ------------------------------------------------------------------
    kma_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_KEYS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (entry_new),
        .rd_en   (s_accept && key_hit),
        .rd_addr (key_full[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // The RAM returns the old contents when the same key was written at the
    // read edge, so the bypass takes precedence over the RAM data.
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) begin
            entry_cur = fwd_data_reg;
        end else if (entry_valid_reg[s1_addr_reg]) begin
            entry_cur = ram_rdata;
        end else begin
            entry_cur = '0;
        end
    end

    kma_key_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .cnt_in        (entry_cur[COUNT_BITS-1:0]),
        .flag_in       (entry_cur[COUNT_BITS]),
        .long_delay    (long_delay_reg),
        .repeat_period (repeat_period_reg),
        .cnt_out       (upd_cnt),
        .flag_out      (upd_flag),
        .emit          (upd_emit),
        .is_repeat     (upd_rep)
    );

    // An open sample clears the key; a closed one takes the updated state.
    assign wr_en     = s1_valid_reg && (s1_cmd_reg == kma_pkg::CMD_SAMPLE) && s1_hit_reg;
    assign entry_new = s1_pressed_reg ? {upd_flag, upd_cnt} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            fwd_valid_reg   <= 1'b0;
        end else begin
            fwd_valid_reg <= wr_en;
            if (wr_en) begin
                entry_valid_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= entry_new;
        end
    end

    // ------------------------------------------------------------------
    // Active set stepping and result formation.
    // ------------------------------------------------------------------
    always_comb begin
        current_set_next = current_set_reg;
        if (s1_valid_reg && (s1_cmd_reg == kma_pkg::CMD_FUNC)) begin
            current_set_next = (current_set_reg >= kma_pkg::SET_LAST) ?
                               kma_pkg::SET_FIRST : current_set_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_set_reg <= kma_pkg::SET_FIRST;
        end else begin
            current_set_reg <= current_set_next;
        end
    end

    always_comb begin
        if (s1_cmd_reg == kma_pkg::CMD_FUNC) begin
            fifo_push           = s1_valid_reg;
            fifo_din.event_kind = kma_pkg::EV_SET;
            fifo_din.key_index  = 4'd0;
            fifo_din.active_set = current_set_next;
            fifo_din.is_repeat  = 1'b0;
        end else begin
            // Inactive keys keep their state but never report.
            fifo_push           = wr_en && s1_pressed_reg && upd_emit && s1_active_reg;
            fifo_din.event_kind = kma_pkg::EV_KEY;
            fifo_din.key_index  = s1_kidx_reg;
            fifo_din.active_set = current_set_reg;
            fifo_din.is_repeat  = upd_rep;
        end
    end

    kma_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data (fifo_din),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .pop_data  (fifo_dout),
        .count     (fifo_count)
    );

    assign m_event_kind = fifo_dout.event_kind;
    assign m_key_index  = fifo_dout.key_index;
    assign m_active_set = fifo_dout.active_set;
    assign m_is_repeat  = fifo_dout.is_repeat;

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_delay_reg    <= kma_pkg::LONG_DELAY_RST;
            repeat_period_reg <= kma_pkg::REPEAT_RST;
        end else if (cfg_wen) begin
            case (cfg_addr)
                kma_pkg::REG_LONG_DELAY: long_delay_reg    <= cfg_wdata;
                kma_pkg::REG_REPEAT:     repeat_period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // A full queue only takes a new result while one leaves it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fifo_push && (fifo_count == 2'(kma_pkg::OUT_DEPTH))) |-> m_ready)
        else $error("result queue overflow");

    // The active set never leaves the range 1 to 3.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (current_set_reg != 2'd0))
        else $error("active set out of range");

    // Every transfer reaches the update stage in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_valid_reg)
        else $error("accepted item lost before update stage");
`endif

endmodule

`default_nettype wire
